// ===== rtl/core/shs_pkg.sv =====
// ----------------------------------------------------------------------------
// shs_pkg
// Types, constants and helper functions shared by the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned ChainDepth = 5;
  localparam int unsigned BlockDepth = 16;
  localparam int unsigned RoundCount = 80;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } wvars_t;

  // Initial chaining value h0..h4
  function automatic word_t init_word(logic [2:0] idx);
    word_t val;
    case (idx)
      3'd0:    val = 32'h67452301;
      3'd1:    val = 32'hEFCDAB89;
      3'd2:    val = 32'h98BADCFE;
      3'd3:    val = 32'h10325476;
      3'd4:    val = 32'hC3D2E1F0;
      default: val = '0;
    endcase
    return val;
  endfunction

  // Additive constant for each group of twenty rounds
  function automatic word_t round_k(logic [6:0] rnd);
    word_t val;
    if (rnd < 7'd20) begin
      val = 32'h5A827999;
    end else if (rnd < 7'd40) begin
      val = 32'h6ED9EBA1;
    end else if (rnd < 7'd60) begin
      val = 32'h8F1BBCDC;
    end else begin
      val = 32'hCA62C1D6;
    end
    return val;
  endfunction

endpackage

// ===== rtl/core/shs_in_if.sv =====
// ----------------------------------------------------------------------------
// shs_in_if
// Input channel of the SHA-1 stream hasher: at most one message byte per item.
// ----------------------------------------------------------------------------
interface shs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       carries_byte;
  logic       is_last;

  modport source (output valid, data_byte, carries_byte, is_last, input ready);
  modport sink   (input valid, data_byte, carries_byte, is_last, output ready);
endinterface

// ===== rtl/core/shs_out_if.sv =====
// ----------------------------------------------------------------------------
// shs_out_if
// Output channel of the SHA-1 stream hasher: one digest word per item.
// ----------------------------------------------------------------------------
interface shs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/core/shs_ram.sv =====
// ----------------------------------------------------------------------------
// shs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module shs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/shs_round.sv =====
// ----------------------------------------------------------------------------
// shs_round
// One SHA-1 compression round: selects the round function and constant,
// forms the new a and shifts the working variables.
// ----------------------------------------------------------------------------
module shs_round
  import shs_pkg::*;
(
  input  wvars_t     vars_i,
  input  word_t      w_i,
  input  logic [6:0] round_i,
  output wvars_t     vars_o
);

  word_t f;
  word_t tmp;

  always_comb begin
    if (round_i < 7'd20) begin
      f = (vars_i.b & vars_i.c) | (~vars_i.b & vars_i.d);
    end else if (round_i < 7'd40 || round_i >= 7'd60) begin
      f = vars_i.b ^ vars_i.c ^ vars_i.d;
    end else begin
      f = (vars_i.b & vars_i.c) | (vars_i.b & vars_i.d) | (vars_i.c & vars_i.d);
    end
  end

  assign tmp = {vars_i.a[26:0], vars_i.a[31:27]} + f + vars_i.e + w_i + round_k(round_i);

  always_comb begin
    vars_o.a = tmp;
    vars_o.b = vars_i.a;
    vars_o.c = {vars_i.b[1:0], vars_i.b[31:2]};
    vars_o.d = vars_i.c;
    vars_o.e = vars_i.d;
  end

endmodule

// ===== rtl/core/sha1_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// SHA-1 over a byte stream, with padding and digest output.
// ----------------------------------------------------------------------------
// Usage:
//   in_i takes one item per message byte; carries_byte = 0 marks an item
//   without a byte, is_last ends the message. in_i.ready is high only
//   while the hasher is idle.
//   The 64th byte of a block starts a compression: the block words and
//   chaining value are loaded from the memories, the rounds run through
//   the single round unit, and the result is folded back into the
//   chaining memory. No item is taken while a compression runs.
//   On the last item, padding writes one byte a cycle up to offset 56,
//   the bit length fills block words 14 and 15 and a final compression runs
//   (plus one extra block when the message ends at offset 56 or beyond).
//   Then out_o carries the five digest words h0..h4, word_index 0..4,
//   last_word on the fifth. A stalled receiver holds the current word;
//   no new item is taken until all five words are delivered.
//   Reset (async, active low) returns to idle with the initial chaining
//   value; after a digest the hasher starts a new message.
// ----------------------------------------------------------------------------
module sha1_stream_hasher
  import shs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  shs_in_if.sink     in_i,
  shs_out_if.source  out_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PAD    = 3'd1;
  localparam logic [2:0] S_LEN_HI = 3'd2;
  localparam logic [2:0] S_LEN_LO = 3'd3;
  localparam logic [2:0] S_LOAD   = 3'd4;
  localparam logic [2:0] S_ROUND  = 3'd5;
  localparam logic [2:0] S_FOLD   = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  localparam int unsigned BlkAddrW = $clog2(BlockDepth);
  localparam int unsigned ChnAddrW = $clog2(ChainDepth);

  logic [2:0]  state_q, state_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [5:0]  pos_q, pos_d;
  logic [63:0] bitlen_q, bitlen_d;
  logic        mark_q, mark_d;
  logic        pad_q, pad_d;
  logic        final_q, final_d;
  logic        fresh_q, fresh_d;
  logic [23:0] pack_q, pack_d;
  wvars_t      wv_q, wv_d;
  word_t       sched_q [BlockDepth];
  word_t       sched_d [BlockDepth];

  logic                put_en;
  logic [7:0]          put_val;
  logic                blk_we;
  logic [BlkAddrW-1:0] blk_waddr;
  word_t               blk_wdata;
  logic [BlkAddrW-1:0] blk_raddr;
  word_t               blk_rdata;
  logic                chn_we;
  logic [ChnAddrW-1:0] chn_waddr;
  word_t               chn_wdata;
  logic [ChnAddrW-1:0] chn_raddr;
  word_t               chn_rdata;

  logic [2:0] prev_idx;
  word_t      chain_val;
  word_t      sched_new;
  wvars_t     round_vars;

  shs_ram #(
    .Width (WordW),
    .Depth (BlockDepth)
  ) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_we),
    .waddr_i (blk_waddr),
    .wdata_i (blk_wdata),
    .raddr_i (blk_raddr),
    .rdata_o (blk_rdata)
  );

  shs_ram #(
    .Width (WordW),
    .Depth (ChainDepth)
  ) u_chn_ram (
    .clk_i   (clk_i),
    .we_i    (chn_we),
    .waddr_i (chn_waddr),
    .wdata_i (chn_wdata),
    .raddr_i (chn_raddr),
    .rdata_o (chn_rdata)
  );

  shs_round u_round (
    .vars_i  (wv_q),
    .w_i     (sched_q[0]),
    .round_i (cnt_q),
    .vars_o  (round_vars)
  );

  // Read data belongs to the address issued in the previous cycle
  assign prev_idx  = cnt_q[2:0] - 3'd1;
  assign chain_val = fresh_q ? init_word(prev_idx) : chn_rdata;
  assign sched_new = {sched_q[13][30:0] ^ sched_q[8][30:0] ^ sched_q[2][30:0] ^ sched_q[0][30:0],
                      sched_q[13][31] ^ sched_q[8][31] ^ sched_q[2][31] ^ sched_q[0][31]};

  assign blk_raddr = cnt_q[BlkAddrW-1:0];
  assign chn_raddr = (cnt_q < 7'(ChainDepth)) ? cnt_q[ChnAddrW-1:0] : '0;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    bitlen_d  = bitlen_q;
    mark_d    = mark_q;
    pad_d     = pad_q;
    final_d   = final_q;
    fresh_d   = fresh_q;
    pack_d    = pack_q;
    wv_d      = wv_q;
    sched_d   = sched_q;
    put_en    = 1'b0;
    put_val   = '0;
    blk_we    = 1'b0;
    blk_waddr = pos_q[5:2];
    blk_wdata = {pack_q, put_val};
    chn_we    = 1'b0;
    chn_waddr = prev_idx;
    chn_wdata = chain_val + wv_q.a;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.carries_byte) begin
            put_en   = 1'b1;
            put_val  = in_i.data_byte;
            bitlen_d = bitlen_q + 64'd8;
          end
          if (in_i.carries_byte && pos_q == 6'd63) begin
            state_d = S_LOAD;
            cnt_d   = '0;
            pad_d   = in_i.is_last;
          end else if (in_i.is_last) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (mark_q && pos_q == 6'd56) begin
          state_d = S_LEN_HI;
        end else begin
          put_en  = 1'b1;
          put_val = mark_q ? 8'h00 : 8'h80;
          mark_d  = 1'b1;
          if (pos_q == 6'd63) begin
            state_d = S_LOAD;
            cnt_d   = '0;
            pad_d   = 1'b1;
          end
        end
      end
      S_LEN_HI: begin
        blk_we    = 1'b1;
        blk_waddr = BlkAddrW'(14);
        blk_wdata = bitlen_q[63:32];
        state_d   = S_LEN_LO;
      end
      S_LEN_LO: begin
        blk_we    = 1'b1;
        blk_waddr = BlkAddrW'(15);
        blk_wdata = bitlen_q[31:0];
        final_d   = 1'b1;
        pad_d     = 1'b0;
        state_d   = S_LOAD;
        cnt_d     = '0;
      end
      S_LOAD: begin
        if (cnt_q != '0) begin
          for (int i = 0; i < BlockDepth - 1; i++) begin
            sched_d[i] = sched_q[i+1];
          end
          sched_d[BlockDepth-1] = blk_rdata;
          if (cnt_q <= 7'(ChainDepth)) begin
            wv_d = '{a: wv_q.b, b: wv_q.c, c: wv_q.d, d: wv_q.e, e: chain_val};
          end
        end
        if (cnt_q == 7'(BlockDepth)) begin
          state_d = S_ROUND;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      S_ROUND: begin
        wv_d = round_vars;
        for (int i = 0; i < BlockDepth - 1; i++) begin
          sched_d[i] = sched_q[i+1];
        end
        sched_d[BlockDepth-1] = sched_new;
        if (cnt_q == 7'(RoundCount - 1)) begin
          state_d = S_FOLD;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      S_FOLD: begin
        if (cnt_q != '0) begin
          chn_we = 1'b1;
          wv_d   = '{a: wv_q.b, b: wv_q.c, c: wv_q.d, d: wv_q.e, e: chn_wdata};
        end
        if (cnt_q == 7'(ChainDepth)) begin
          cnt_d = '0;
          if (final_q) begin
            // Digest ready: restart the message state
            state_d  = S_OUT;
            fresh_d  = 1'b1;
            bitlen_d = '0;
            pos_d    = '0;
            mark_d   = 1'b0;
            final_d  = 1'b0;
          end else begin
            fresh_d = 1'b0;
            state_d = pad_q ? S_PAD : S_IDLE;
          end
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      S_OUT: begin
        if (out_o.ready) begin
          wv_d = '{a: wv_q.b, b: wv_q.c, c: wv_q.d, d: wv_q.e, e: wv_q.a};
          if (cnt_q == 7'(ChainDepth - 1)) begin
            state_d = S_IDLE;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + 7'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Pack bytes big-endian; write a word once its fourth byte arrives
    if (put_en) begin
      blk_wdata = {pack_q, put_val};
      if (pos_q[1:0] == 2'd3) begin
        blk_we = 1'b1;
      end
      pack_d = {pack_q[15:0], put_val};
      pos_d  = pos_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      pos_q    <= '0;
      bitlen_q <= '0;
      mark_q   <= 1'b0;
      pad_q    <= 1'b0;
      final_q  <= 1'b0;
      fresh_q  <= 1'b1;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pos_q    <= pos_d;
      bitlen_q <= bitlen_d;
      mark_q   <= mark_d;
      pad_q    <= pad_d;
      final_q  <= final_d;
      fresh_q  <= fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pack_q  <= pack_d;
    wv_q    <= wv_d;
    sched_q <= sched_d;
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = (state_q == S_OUT);
  assign out_o.digest_word = wv_q.a;
  assign out_o.word_index  = cnt_q[2:0];
  assign out_o.last_word   = (cnt_q == 7'(ChainDepth - 1));

endmodule

// ===== rtl/core/shs_checker.sv =====
// ----------------------------------------------------------------------------
// shs_checker
// Port-level checks for the SHA-1 stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
module shs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] digest_word_i,
  input logic [2:0]  word_index_i,
  input logic        last_word_i
);

  // No new item while a digest is being delivered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready while digest words pending");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(digest_word_i) && $stable(word_index_i))
    else $error("stalled digest word changed");

  // Words follow one another without gaps, index advancing by one
  a_next_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_word_i |=>
      out_valid_i && word_index_i == $past(word_index_i) + 3'd1)
    else $error("digest word sequence broken");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> last_word_i == (word_index_i == 3'd4))
    else $error("last_word does not match word_index");

  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && last_word_i |=> in_ready_i)
    else $error("hasher not idle after final digest word");

  logic unused_in_valid;
  assign unused_in_valid = in_valid_i;

endmodule

bind sha1_stream_hasher shs_checker u_shs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .digest_word_i (out_o.digest_word),
  .word_index_i  (out_o.word_index),
  .last_word_i   (out_o.last_word)
);
